FILE: rtl/core/ctlc_pkg.sv
// ----------------------------------------------------------------------------
// Counted loop trip count package
// Shared types and constants for the trip count pipeline.
// ----------------------------------------------------------------------------
package ctlc_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned DivSteps  = DataWidth;

   localparam logic [2:0] MODE_LT = 3'd0;
   localparam logic [2:0] MODE_LE = 3'd1;
   localparam logic [2:0] MODE_GT = 3'd2;
   localparam logic [2:0] MODE_GE = 3'd3;

   // Work carried down the pipeline: two division lanes share one divisor.
   typedef struct packed {
      logic                 bad;     // count not known
      logic                 zero;    // start already fails the compare
      logic                 strict;  // strict compare: ceiling division
      logic [DataWidth-1:0] mag;     // step magnitude (divisor)
      logic [DataWidth-1:0] rem_d;   // distance lane remainder
      logic [DataWidth-1:0] quo_d;   // distance lane dividend / quotient
      logic [DataWidth-1:0] rem_r;   // headroom lane remainder
      logic [DataWidth-1:0] quo_r;   // headroom lane dividend / quotient
   } ctlc_work_type;

endpackage

FILE: rtl/core/ctlc_front.sv
// ----------------------------------------------------------------------------
// Trip count setup
// Classifies the loop and forms distance, headroom and step magnitude.
// ----------------------------------------------------------------------------
module ctlc_front import ctlc_pkg::*; (
   input  logic [2:0]           mode,
   input  logic [DataWidth-1:0] start_req,
   input  logic [DataWidth-1:0] limit,
   input  logic [DataWidth-1:0] step,
   input  logic                 limit_known,
   output ctlc_work_type        work
);

   logic up;
   logic strict;
   logic mode_ok;
   logic fails;

   always_comb begin
      up      = ~step[DataWidth-1];
      mode_ok = up ? (mode == MODE_LT || mode == MODE_LE)
                   : (mode == MODE_GT || mode == MODE_GE);
      strict  = up ? (mode == MODE_LT) : (mode == MODE_GT);
      if (up) begin
         fails = strict ? !($signed(start_req) < $signed(limit))
                        : ($signed(limit) < $signed(start_req));
      end else begin
         fails = strict ? !($signed(limit) < $signed(start_req))
                        : ($signed(start_req) < $signed(limit));
      end

      work.bad    = !limit_known || (step == '0) || !mode_ok;
      work.zero   = fails;
      work.strict = strict;
      work.mag    = up ? step : ('0 - step);
      work.rem_d  = '0;
      work.rem_r  = '0;
      if (up) begin
         work.quo_d = limit - start_req;
         work.quo_r = {1'b0, {(DataWidth-1){1'b1}}} - start_req;
      end else begin
         work.quo_d = start_req - limit;
         work.quo_r = start_req - {1'b1, {(DataWidth-1){1'b0}}};
      end
   end

endmodule

FILE: rtl/core/ctlc_div_step.sv
// ----------------------------------------------------------------------------
// Division step
// One restoring division iteration on both lanes against a shared divisor.
// ----------------------------------------------------------------------------
module ctlc_div_step import ctlc_pkg::*; (
   input  ctlc_work_type work_in,
   output ctlc_work_type work_out
);

   logic [DataWidth:0] part_d;
   logic [DataWidth:0] part_r;
   logic [DataWidth:0] diff_d;
   logic [DataWidth:0] diff_r;
   logic               ge_d;
   logic               ge_r;

   always_comb begin
      part_d = {work_in.rem_d, work_in.quo_d[DataWidth-1]};
      part_r = {work_in.rem_r, work_in.quo_r[DataWidth-1]};
      diff_d = part_d - {1'b0, work_in.mag};
      diff_r = part_r - {1'b0, work_in.mag};
      ge_d   = part_d >= {1'b0, work_in.mag};
      ge_r   = part_r >= {1'b0, work_in.mag};

      work_out       = work_in;
      work_out.rem_d = ge_d ? diff_d[DataWidth-1:0] : part_d[DataWidth-1:0];
      work_out.rem_r = ge_r ? diff_r[DataWidth-1:0] : part_r[DataWidth-1:0];
      work_out.quo_d = {work_in.quo_d[DataWidth-2:0], ge_d};
      work_out.quo_r = {work_in.quo_r[DataWidth-2:0], ge_r};
   end

endmodule

FILE: rtl/core/ctlc_back.sv
// ----------------------------------------------------------------------------
// Trip count finish
// Rounds the quotient into a count and checks it against the headroom.
// ----------------------------------------------------------------------------
module ctlc_back import ctlc_pkg::*; (
   input  ctlc_work_type        work,
   output logic [DataWidth-1:0] iter_count,
   output logic                 known
);

   logic [DataWidth-1:0] n;
   logic                 wrap;

   always_comb begin
      wrap = 1'b0;
      if (work.strict) begin
         n = work.quo_d + {{(DataWidth-1){1'b0}}, (work.rem_d != '0)};
      end else begin
         wrap = (work.quo_d == '1);
         n    = work.quo_d + {{(DataWidth-1){1'b0}}, 1'b1};
      end

      if (work.bad) begin
         known      = 1'b0;
         iter_count = '0;
      end else if (work.zero) begin
         known      = 1'b1;
         iter_count = '0;
      end else if (wrap || (n > work.quo_r)) begin
         known      = 1'b0;
         iter_count = '0;
      end else begin
         known      = 1'b1;
         iter_count = n;
      end
   end

endmodule

FILE: rtl/core/counted_loop_trip_count_top.sv
// ----------------------------------------------------------------------------
// Counted loop trip count
// Pipelined computation of a counted loop's iteration count.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_stall   mode, start_req, limit, step,
//                                             limit_known
//   rsp_     out        rsp_valid/rsp_stall   iteration count, known
//
// One transaction enters per cycle while no result is stalled, and passes
// through 66 register stages: one setup stage, 64 restoring division stages
// (one quotient bit each for the distance and the headroom lanes), and one
// output register. The setup stage is loaded at the accepting edge, and the
// result is offered from the output register after the division stages.
// The sustained rate is one transaction per cycle while no result is stalled;
// the division pipeline sets the latency.
// Reset clears the valid bits of every stage; the payload registers are not
// reset.
// A stalled result freezes the whole pipeline, so no transaction is lost or
// repeated; req_stall is raised only while a waiting result is stalled.
// ----------------------------------------------------------------------------
module counted_loop_trip_count_top import ctlc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_mode,
   input  logic [DataWidth-1:0] req_start_req,
   input  logic [DataWidth-1:0] req_limit,
   input  logic [DataWidth-1:0] req_step,
   input  logic                 req_limit_known,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DataWidth-1:0] rsp_trip_count,
   output logic                 rsp_known
);

   // The pipeline moves whenever the output register is free or being taken.
   logic advance;

   ctlc_work_type        front_work;
   ctlc_work_type        stage_ff   [0:DivSteps];
   ctlc_work_type        stage_in   [1:DivSteps];
   logic [DivSteps:0]    valid_ff;
   logic [DataWidth-1:0] back_count;
   logic                 back_known;
   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] rsp_trip_count_ff;
   logic                 rsp_known_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Setup: classify the loop and form the dividends and divisor.
   ctlc_front u_front (
      .mode        (req_mode),
      .start_req   (req_start_req),
      .limit       (req_limit),
      .step        (req_step),
      .limit_known (req_limit_known),
      .work        (front_work)
   );

   // Each division stage retires one quotient bit on both lanes.
   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      ctlc_div_step u_step (
         .work_in  (stage_ff[i]),
         .work_out (stage_in[i+1])
      );
   end

   // Final rounding and headroom check on the last stage.
   ctlc_back u_back (
      .work       (stage_ff[DivSteps]),
      .iter_count (back_count),
      .known      (back_known)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= front_work;
         for (int k = 1; k <= DivSteps; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         rsp_trip_count_ff <= back_count;
         rsp_known_ff      <= back_known;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[DivSteps-1:0], req_valid};
         rsp_valid_ff <= valid_ff[DivSteps];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_trip_count = rsp_trip_count_ff;
   assign rsp_known      = rsp_known_ff;

endmodule

FILE: tb/counted_loop_trip_count_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Counted loop trip count testbench
// Drives loop descriptors into the trip count pipeline. Each one is also
// evaluated by a behavioral predictor, and every result is compared in order
// against that prediction. Both channels idle at random in two of three phases.
// ----------------------------------------------------------------------------
module counted_loop_trip_count_top_test;
   import ctlc_pkg::*;

   localparam int unsigned LatencyCycles = 65;
   localparam longint unsigned CycleLimit = 200000;
   localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MaxPos  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MinNeg  = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] start_val;
      logic [63:0] limit;
      logic [63:0] step;
      logic        limit_known;
   } loop_desc_type;

   typedef struct packed {
      logic [63:0] iter_count;
      logic        known;
   } trip_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_mode;
   logic [63:0] req_start_req;
   logic [63:0] req_limit;
   logic [63:0] req_step;
   logic req_limit_known;
   logic rsp_valid;
   logic rsp_stall;
   logic [63:0] rsp_trip_count;
   logic rsp_known;

   counted_loop_trip_count_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_start_req   (req_start_req),
      .req_limit       (req_limit),
      .req_step        (req_step),
      .req_limit_known (req_limit_known),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_trip_count  (rsp_trip_count),
      .rsp_known       (rsp_known)
   );

   // Descriptors waiting to be driven and trip counts waiting to come back.
   loop_desc_type pending_loops[$];
   trip_type expected_trips[$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit req_taken;
   int unsigned mismatch_count;
   int unsigned trips_checked;
   int unsigned known_seen;
   longint unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Signed less-than on raw 64-bit patterns.
   function automatic bit slt(logic [63:0] a, logic [63:0] b);
      return (a ^ SignBit) < (b ^ SignBit);
   endfunction

   // Predicts the iteration count of one loop descriptor.
   function automatic trip_type predict_trip(loop_desc_type d);
      trip_type r;
      logic [63:0] gap, mag, room, n;
      bit strict_cmp;
      r = '0;
      if (!d.limit_known || d.step == 0) return r;
      if (!d.step[63]) begin
         // Counting up: only the less-than modes make sense.
         if (d.mode == MODE_LT) strict_cmp = 1'b1;
         else if (d.mode == MODE_LE) strict_cmp = 1'b0;
         else return r;
         mag = d.step;
         if (strict_cmp ? !slt(d.start_val, d.limit) : slt(d.limit, d.start_val)) begin
            r.known = 1'b1;
            return r;
         end
         gap = d.limit - d.start_val;
         room = MaxPos - d.start_val;
      end else begin
         if (d.mode == MODE_GT) strict_cmp = 1'b1;
         else if (d.mode == MODE_GE) strict_cmp = 1'b0;
         else return r;
         mag = 64'd0 - d.step;
         if (strict_cmp ? !slt(d.limit, d.start_val) : slt(d.start_val, d.limit)) begin
            r.known = 1'b1;
            return r;
         end
         gap = d.start_val - d.limit;
         room = d.start_val - SignBit;
      end
      n = gap / mag;
      if (strict_cmp) begin
         if (gap % mag != 0) n = n + 1;
      end else begin
         // An inclusive count of 2^64 does not fit.
         if (n == '1) return r;
         n = n + 1;
      end
      // The value tested after the final update must stay in range.
      if (n > room / mag) return r;
      r.iter_count = n;
      r.known = 1'b1;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Picks an interesting 64-bit value: extremes, small numbers or noise.
   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 5))
         0: return MaxPos - 64'($urandom_range(0, 3));
         1: return MinNeg + 64'($urandom_range(0, 3));
         2: return 64'($signed($urandom_range(0, 200)) - 100);
         default: return rand64();
      endcase
   endfunction

   // Builds a loop that is mostly well formed: direction matches the mode
   // and the limit lies a random distance ahead of the start.
   function automatic loop_desc_type make_loop();
      loop_desc_type d;
      logic [63:0] span, mag;
      d.limit_known = ($urandom_range(0, 19) != 0);
      d.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                            : 3'($urandom_range(0, 3));
      d.start_val = pick_value();
      case ($urandom_range(0, 3))
         0: mag = 64'($urandom_range(1, 8));
         1: mag = 64'($urandom_range(1, 100000));
         2: mag = rand64() >> $urandom_range(0, 63);
         default: mag = rand64();
      endcase
      if (mag == 0) mag = 1;
      case ($urandom_range(0, 2))
         0: span = 64'($urandom_range(0, 1000));
         1: span = rand64() >> $urandom_range(0, 63);
         default: span = rand64();
      endcase
      if ($urandom_range(0, 9) == 0) d.step = '0;
      else if (d.mode == MODE_GT || d.mode == MODE_GE) d.step = 64'd0 - mag;
      else d.step = mag;
      if ($urandom_range(0, 7) == 0) d.step = -d.step;
      if (d.step[63]) d.limit = d.start_val - span;
      else d.limit = d.start_val + span;
      if ($urandom_range(0, 9) == 0) d.limit = pick_value();
      return d;
   endfunction

   task automatic add_loop(logic [2:0] mode, logic [63:0] start_val, logic [63:0] limit,
                           logic [63:0] step, logic limit_known);
      loop_desc_type d;
      d.mode = mode;
      d.start_val = start_val;
      d.limit = limit;
      d.step = step;
      d.limit_known = limit_known;
      pending_loops.push_back(d);
   endtask

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("Mismatch on %s at cycle %0d: got %h, expected %h",
               field, cycle_count, got, want);
      mismatch_count++;
   endtask

   // Records whether the offered transaction was taken at this rising edge.
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
   end

   // Driver: offers the head of the queue, changing inputs at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // Nothing is held, or the last transaction was taken at the rising edge.
         if (pending_loops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_mode <= pending_loops[0].mode;
            req_start_req <= pending_loops[0].start_val;
            req_limit <= pending_loops[0].limit;
            req_step <= pending_loops[0].step;
            req_limit_known <= pending_loops[0].limit_known;
            expected_trips.push_back(predict_trip(pending_loops[0]));
            void'(pending_loops.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= reset ? 1'b0 : ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Monitor: checks each accepted result against the oldest prediction.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_trips.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_trip_count, '0);
         end else begin
            if (rsp_trip_count !== expected_trips[0].iter_count)
               report_mismatch("iteration count", rsp_trip_count,
                               expected_trips[0].iter_count);
            if (rsp_known !== expected_trips[0].known)
               report_mismatch("known", 64'(rsp_known), 64'(expected_trips[0].known));
            if (expected_trips[0].known) known_seen++;
            trips_checked++;
            void'(expected_trips.pop_front());
         end
      end
   end

   // Ends the run if it stalls far beyond any correct schedule.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      req_valid = 1'b0;
      req_mode = '0;
      req_start_req = '0;
      req_limit = '0;
      req_step = '0;
      req_limit_known = 1'b0;
      rsp_stall = 1'b0;
      req_taken = 1'b0;
      reset = 1'b1;
      cycle_count = 0;
      mismatch_count = 0;
      trips_checked = 0;
      known_seen = 0;
      send_idle_pct = 20;
      recv_idle_pct = 80;

      // Directed loops: each mode, unknown limit, zero step, direction
      // mismatch, start already failing, count of 2^64 and exit overflow.
      add_loop(MODE_LT, 64'd0, 64'd10, 64'd3, 1'b1);
      add_loop(MODE_LE, 64'd0, 64'd9, 64'd3, 1'b1);
      add_loop(MODE_GT, 64'd10, 64'd0, -64'sd3, 1'b1);
      add_loop(MODE_GE, 64'd9, 64'd0, -64'sd3, 1'b1);
      add_loop(MODE_LT, 64'd0, 64'd10, 64'd1, 1'b0);
      add_loop(MODE_LT, 64'd0, 64'd10, 64'd0, 1'b1);
      add_loop(MODE_GT, 64'd0, 64'd10, 64'd1, 1'b1);
      add_loop(MODE_LE, 64'd10, 64'd0, -64'sd1, 1'b1);
      add_loop(MODE_GT, 64'd20, 64'd0, 64'd1, 1'b1);
      add_loop(3'd4, 64'd0, 64'd10, 64'd1, 1'b1);
      add_loop(3'd7, 64'd10, 64'd0, -64'sd1, 1'b1);
      add_loop(MODE_LT, 64'd10, 64'd10, 64'd1, 1'b1);
      add_loop(MODE_LE, 64'd11, 64'd10, 64'd1, 1'b1);
      add_loop(MODE_GE, 64'd9, 64'd10, -64'sd1, 1'b1);
      add_loop(MODE_LE, MinNeg, MaxPos, 64'd1, 1'b1);
      add_loop(MODE_LE, 64'd0, MaxPos, 64'd1, 1'b1);
      add_loop(MODE_LT, MinNeg, MaxPos, 64'd1, 1'b1);
      add_loop(MODE_GE, MaxPos, MinNeg, MinNeg, 1'b1);
      add_loop(MODE_GT, MaxPos, MinNeg, -64'sd1, 1'b1);
      add_loop(MODE_LT, 64'd0, MaxPos, MaxPos, 1'b1);
      add_loop(MODE_LE, 64'd0, MaxPos, MaxPos, 1'b1);
      add_loop(MODE_GE, -64'sd1, MinNeg, MinNeg, 1'b1);
      add_loop(MODE_LT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5, 64'h7FFF_0000_0000_0000, 1'b1);
      for (int i = 0; i < 1450; i++) begin
         loop_desc_type d;
         d = make_loop();
         pending_loops.push_back(d);
      end

      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Three phases of about a third of the stimulus each; the last never idles.
      while (pending_loops.size() > 980) @(posedge clock);
      send_idle_pct = 80;
      recv_idle_pct = 20;
      while (pending_loops.size() > 490) @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (pending_loops.size() != 0 || req_valid) @(posedge clock);
      while (expected_trips.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 4) @(posedge clock);

      $display("Checked %0d trip counts, %0d of them known, over %0d cycles.",
               trips_checked, known_seen, cycle_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches found", mismatch_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: counted_loop_trip_count_top.f
rtl/core/ctlc_pkg.sv
rtl/core/ctlc_front.sv
rtl/core/ctlc_div_step.sv
rtl/core/ctlc_back.sv
rtl/core/counted_loop_trip_count_top.sv
tb/counted_loop_trip_count_top_test.sv
